[design/http_chunked_body_decoder_assert.svh]
// ---------------------------------------------------------------------------
// http_chunked_body_decoder_assert.svh
// Assertion macros shared by the decoder modules.
// ---------------------------------------------------------------------------
`ifndef HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH
`define HTTP_CHUNKED_BODY_DECODER_ASSERT_SVH

// Same-cycle implication, checked on every clock edge out of reset.
`define HCBD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("hcbd assertion failed");

// Next-cycle implication.
`define HCBD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("hcbd assertion failed");

`endif

[design/hcbd_pkg.sv]
// ---------------------------------------------------------------------------
// hcbd_pkg
// Types, codes and helpers for the chunked body decoder.
// ---------------------------------------------------------------------------
package hcbd_pkg;

    localparam logic [7:0] BYTE_CR = 8'h0D;
    localparam logic [7:0] BYTE_LF = 8'h0A;
    localparam logic [31:0] MAX_BODY_RESET = 32'd65536;

    typedef enum logic [1:0] {
        KIND_PAYLOAD = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_ERROR   = 2'd2
    } t_kind;

    typedef enum logic [7:0] {
        PH_SIZE    = 8'b0000_0001,
        PH_EXT     = 8'b0000_0010,
        PH_SIZE_LF = 8'b0000_0100,
        PH_DATA    = 8'b0000_1000,
        PH_END_CR  = 8'b0001_0000,
        PH_END_LF  = 8'b0010_0000,
        PH_DONE    = 8'b0100_0000,
        PH_ERROR   = 8'b1000_0000
    } t_phase;

    // One input beat as it travels from the skid buffer to the parser.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       new_body;
    } t_in_beat;

    typedef struct packed {
        logic       is_hex;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_decode(input logic [7:0] b);
        t_hex h;
        h.is_hex = 1'b1;
        h.value  = 4'd0;
        if (b >= 8'h30 && b <= 8'h39) begin
            h.value = 4'(b - 8'h30);
        end else if (b >= 8'h41 && b <= 8'h46) begin
            h.value = 4'(b - 8'h37);
        end else if (b >= 8'h61 && b <= 8'h66) begin
            h.value = 4'(b - 8'h57);
        end else begin
            h.is_hex = 1'b0;
        end
        return h;
    endfunction

endpackage

[design/http_chunked_body_decoder.sv]
// ---------------------------------------------------------------------------
// http_chunked_body_decoder
// Byte-serial decoder for an HTTP/1.1 chunked message body.
// ---------------------------------------------------------------------------
//  channel  | valid    | stall    | payload
//  ---------+----------+----------+-----------------------------------------
//  input    | i_valid  | o_stall  | i_in_byte, i_new_body
//  output   | o_valid  | i_stall  | o_out_kind, o_out_byte, o_body_length
//  config   | i_cfg_wr_en         | i_cfg_wr_data (max_body_len)
//
//  One byte per cycle sustained while i_stall is low; results are registered.
//  The parser advances one beat per cycle while the result register is free.
//  o_stall comes from the input skid flop, so it never depends on i_stall.
//  Synchronous active-low reset clears the parse state and loads
//  max_body_len with 65536.
// ---------------------------------------------------------------------------
module http_chunked_body_decoder #(
    parameter int LEN_BITS = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_in_byte,
    input  logic        i_new_body,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_out_kind,
    output logic [7:0]  o_out_byte,
    output logic [31:0] o_body_length,
    input  logic        i_cfg_wr_en,
    input  logic [31:0] i_cfg_wr_data
);

    logic [31:0]        r_max_body_len;
    logic               beat_valid;
    hcbd_pkg::t_in_beat beat;
    logic               pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_body_len <= hcbd_pkg::MAX_BODY_RESET;
        end else if (i_cfg_wr_en) begin
            r_max_body_len <= i_cfg_wr_data;
        end
    end

    hcbd_in_skid u_in_skid (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_in_byte    (i_in_byte),
        .i_new_body   (i_new_body),
        .o_beat_valid (beat_valid),
        .o_beat       (beat),
        .i_pop        (pop)
    );

    hcbd_core #(
        .LEN_BITS (LEN_BITS)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_beat_valid   (beat_valid),
        .i_beat         (beat),
        .o_pop          (pop),
        .i_max_body_len (r_max_body_len),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_out_kind     (o_out_kind),
        .o_out_byte     (o_out_byte),
        .o_body_length  (o_body_length)
    );

endmodule

[design/hcbd_in_skid.sv]
// ---------------------------------------------------------------------------
// hcbd_in_skid
// Two-entry input buffer; stall toward the sender comes from a flop.
// ---------------------------------------------------------------------------
module hcbd_in_skid (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [7:0]        i_in_byte,
    input  logic              i_new_body,
    output logic              o_beat_valid,
    output hcbd_pkg::t_in_beat o_beat,
    input  logic              i_pop
);

    logic               r_m_valid, n_m_valid;
    logic               r_s_valid, n_s_valid;
    hcbd_pkg::t_in_beat r_m_beat, n_m_beat;
    hcbd_pkg::t_in_beat r_s_beat, n_s_beat;
    hcbd_pkg::t_in_beat in_beat;
    logic               accept;

    assign in_beat.in_byte  = i_in_byte;
    assign in_beat.new_body = i_new_body;
    assign o_stall          = r_s_valid;
    assign accept           = i_valid && !r_s_valid;
    assign o_beat_valid     = r_m_valid;
    assign o_beat           = r_m_beat;

    always_comb begin
        n_m_valid = r_m_valid;
        n_s_valid = r_s_valid;
        n_m_beat  = r_m_beat;
        n_s_beat  = r_s_beat;
        if (i_pop) begin
            if (r_s_valid) begin
                n_m_valid = 1'b1;
                n_m_beat  = r_s_beat;
                n_s_valid = 1'b0;
            end else begin
                n_m_valid = accept;
                n_m_beat  = in_beat;
            end
        end else if (!r_m_valid) begin
            n_m_valid = accept;
            n_m_beat  = in_beat;
        end else if (accept) begin
            n_s_valid = 1'b1;
            n_s_beat  = in_beat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
            r_s_valid <= 1'b0;
        end else begin
            r_m_valid <= n_m_valid;
            r_s_valid <= n_s_valid;
        end
        r_m_beat <= n_m_beat;
        r_s_beat <= n_s_beat;
    end

`include "http_chunked_body_decoder_assert.svh"

    // skid slot only fills behind an occupied main slot
    `HCBD_ASSERT_NOW(a_skid_behind_main, r_s_valid, r_m_valid)

endmodule

[design/hcbd_core.sv]
// ---------------------------------------------------------------------------
// hcbd_core
// Chunk framing parser with the result register.
// ---------------------------------------------------------------------------
module hcbd_core #(
    parameter int LEN_BITS = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_beat_valid,
    input  hcbd_pkg::t_in_beat i_beat,
    output logic               o_pop,
    input  logic [31:0]        i_max_body_len,
    output logic               o_valid,
    input  logic               i_stall,
    output logic [1:0]         o_out_kind,
    output logic [7:0]         o_out_byte,
    output logic [31:0]        o_body_length
);

    localparam int CMP_W = (LEN_BITS > 32) ? LEN_BITS : 32;

    hcbd_pkg::t_phase     r_phase, n_phase, cur_phase;
    logic [LEN_BITS-1:0]  r_chunk, n_chunk, cur_chunk;
    logic [31:0]          r_total, n_total, cur_total;
    logic                 r_size_zero, n_size_zero, cur_size_zero;

    logic                 r_out_valid;
    hcbd_pkg::t_kind      r_kind, n_kind;
    logic [7:0]           r_byte, n_byte;
    logic [31:0]          r_len;

    logic                 out_free;
    logic                 adv;
    logic                 res_load;
    hcbd_pkg::t_hex       hex;
    logic [31:0]          room;
    logic                 too_big;

    assign out_free = !r_out_valid || !i_stall;
    assign adv      = i_beat_valid && out_free;
    assign o_pop    = adv;

    assign cur_phase     = i_beat.new_body ? hcbd_pkg::PH_SIZE : r_phase;
    assign cur_chunk     = i_beat.new_body ? '0 : r_chunk;
    assign cur_total     = i_beat.new_body ? 32'd0 : r_total;
    assign cur_size_zero = i_beat.new_body ? 1'b1 : r_size_zero;

    assign hex     = hcbd_pkg::hex_decode(i_beat.in_byte);
    assign room    = i_max_body_len - cur_total;
    assign too_big = (cur_total > i_max_body_len) || (CMP_W'(cur_chunk) > CMP_W'(room));

    always_comb begin
        n_phase     = cur_phase;
        n_chunk     = cur_chunk;
        n_total     = cur_total;
        n_size_zero = cur_size_zero;
        res_load    = 1'b0;
        n_kind      = hcbd_pkg::KIND_PAYLOAD;
        n_byte      = 8'd0;
        unique case (cur_phase)
            hcbd_pkg::PH_SIZE: begin
                if (hex.is_hex) begin
                    if (cur_chunk[LEN_BITS-1 -: 4] != 4'd0) begin
                        n_phase  = hcbd_pkg::PH_ERROR;
                        res_load = 1'b1;
                        n_kind   = hcbd_pkg::KIND_ERROR;
                    end else begin
                        n_chunk = {cur_chunk[LEN_BITS-5:0], hex.value};
                        if (hex.value != 4'd0) begin
                            n_size_zero = 1'b0;
                        end
                    end
                end else if (i_beat.in_byte == hcbd_pkg::BYTE_CR) begin
                    n_phase = hcbd_pkg::PH_SIZE_LF;
                end else begin
                    n_phase = hcbd_pkg::PH_EXT;
                end
            end
            hcbd_pkg::PH_EXT: begin
                if (i_beat.in_byte == hcbd_pkg::BYTE_CR) begin
                    n_phase = hcbd_pkg::PH_SIZE_LF;
                end
            end
            hcbd_pkg::PH_SIZE_LF: begin
                priority if (i_beat.in_byte == hcbd_pkg::BYTE_CR) begin
                    n_phase = hcbd_pkg::PH_SIZE_LF;
                end else if (i_beat.in_byte != hcbd_pkg::BYTE_LF) begin
                    n_phase = hcbd_pkg::PH_EXT;
                end else if (cur_size_zero) begin
                    n_phase = hcbd_pkg::PH_END_CR;
                end else if (too_big) begin
                    n_phase  = hcbd_pkg::PH_ERROR;
                    res_load = 1'b1;
                    n_kind   = hcbd_pkg::KIND_ERROR;
                end else begin
                    n_phase = hcbd_pkg::PH_DATA;
                end
            end
            hcbd_pkg::PH_DATA: begin
                n_total  = cur_total + 32'd1;
                n_chunk  = cur_chunk - LEN_BITS'(1);
                res_load = 1'b1;
                n_kind   = hcbd_pkg::KIND_PAYLOAD;
                n_byte   = i_beat.in_byte;
                if (n_chunk == '0) begin
                    n_phase = hcbd_pkg::PH_END_CR;
                end
            end
            hcbd_pkg::PH_END_CR: begin
                if (i_beat.in_byte != hcbd_pkg::BYTE_CR) begin
                    n_phase  = hcbd_pkg::PH_ERROR;
                    res_load = 1'b1;
                    n_kind   = hcbd_pkg::KIND_ERROR;
                end else begin
                    n_phase = hcbd_pkg::PH_END_LF;
                end
            end
            hcbd_pkg::PH_END_LF: begin
                priority if (i_beat.in_byte != hcbd_pkg::BYTE_LF) begin
                    n_phase  = hcbd_pkg::PH_ERROR;
                    res_load = 1'b1;
                    n_kind   = hcbd_pkg::KIND_ERROR;
                end else if (cur_size_zero) begin
                    n_phase  = hcbd_pkg::PH_DONE;
                    res_load = 1'b1;
                    n_kind   = hcbd_pkg::KIND_DONE;
                end else begin
                    n_phase     = hcbd_pkg::PH_SIZE;
                    n_chunk     = '0;
                    n_size_zero = 1'b1;
                end
            end
            hcbd_pkg::PH_DONE, hcbd_pkg::PH_ERROR: begin
                n_phase = cur_phase;
            end
            default: begin
                n_phase = hcbd_pkg::PH_ERROR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= hcbd_pkg::PH_SIZE;
            r_chunk     <= '0;
            r_total     <= 32'd0;
            r_size_zero <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_phase     <= n_phase;
                r_chunk     <= n_chunk;
                r_total     <= n_total;
                r_size_zero <= n_size_zero;
            end
            if (out_free) begin
                r_out_valid <= adv && res_load;
            end
        end
        if (adv && res_load) begin
            r_kind <= n_kind;
            r_byte <= n_byte;
            r_len  <= n_total;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_out_kind    = r_kind;
    assign o_out_byte    = r_byte;
    assign o_body_length = r_len;

`include "http_chunked_body_decoder_assert.svh"

    // a finished or failed body stays silent until a new body starts
    `HCBD_ASSERT_NOW(a_quiet_after_end,
        adv && !i_beat.new_body && (r_phase == hcbd_pkg::PH_DONE || r_phase == hcbd_pkg::PH_ERROR),
        !res_load)
    // payload phase always owes at least one byte of a nonzero chunk
    `HCBD_ASSERT_NOW(a_data_owes_bytes, r_phase == hcbd_pkg::PH_DATA,
        (r_chunk != '0) && !r_size_zero)
    // a completion result always leaves the parser in the done phase
    `HCBD_ASSERT_NEXT(a_done_sets_phase, adv && res_load && n_kind == hcbd_pkg::KIND_DONE,
        r_phase == hcbd_pkg::PH_DONE && r_out_valid)

endmodule
